@@ sv/erm_pkg.sv @@
// erm_pkg: shared constants, types and helpers for the q12 rotation matrix block
// used by euler_to_rotation_matrix_q12 and its checker; no dependencies
package erm_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned IdxW         = $clog2(TableEntries);
  localparam int unsigned AngleW       = 16;
  localparam int unsigned TrigW        = 16;
  localparam int unsigned WordW        = 2 * TrigW;
  localparam int unsigned FracW        = 12;
  localparam int unsigned Prod1W       = 2 * TrigW;
  localparam int unsigned Lvl1W        = Prod1W - FracW;
  localparam int unsigned Prod2W       = Lvl1W + TrigW;
  localparam int unsigned Latency      = 5;

  localparam logic [WordW-1:0] GoodEntry0 = 32'h1000_0000;

  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_COMPUTE = 1'b1
  } func_e;

  typedef logic signed [TrigW-1:0] trig_t;

  // table index: |angle| kept to the low index bits
  function automatic logic [IdxW-1:0] trig_index(input logic signed [AngleW-1:0] angle);
    logic [IdxW-1:0] low;
    low = angle[IdxW-1:0];
    return angle[AngleW-1] ? (IdxW'(0) - low) : low;
  endfunction

  // sine with sign of the angle applied; negation wraps at the most negative value
  function automatic trig_t sine_fix(input logic [TrigW-1:0] raw, input logic neg);
    return neg ? trig_t'(TrigW'(0) - raw) : trig_t'(raw);
  endfunction

endpackage

@@ sv/euler_to_rotation_matrix_q12.sv @@
// euler_to_rotation_matrix_q12: 3x3 q12 rotation matrix from three euler angles,
// looked up in a packed sine/cosine table loaded word by word
// depends on erm_pkg
//
// a compute word is registered through the table read and stages 1 to 4, and done_o
//   is high with its result once it leaves stage 4; a write word gives no result
// throughput: one word per cycle while busy_o is low; all five stages, table read
//   included, take a new word every cycle
// busy_o is high in reset and in the first cycle after it, low afterwards: the
//   receiver cannot stall, so the pipeline never holds
// reset clears only control; the table holds no valid data until it is written
module euler_to_rotation_matrix_q12 (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic                              func_i,
  input  logic [erm_pkg::IdxW-1:0]          table_index_i,
  input  logic [erm_pkg::WordW-1:0]         table_word_i,
  input  logic signed [erm_pkg::AngleW-1:0] angle_x_i,
  input  logic signed [erm_pkg::AngleW-1:0] angle_y_i,
  input  logic signed [erm_pkg::AngleW-1:0] angle_z_i,
  output logic                              done_o,
  output logic signed [erm_pkg::TrigW-1:0]  m00_o,
  output logic signed [erm_pkg::TrigW-1:0]  m01_o,
  output logic signed [erm_pkg::TrigW-1:0]  m02_o,
  output logic signed [erm_pkg::TrigW-1:0]  m10_o,
  output logic signed [erm_pkg::TrigW-1:0]  m11_o,
  output logic signed [erm_pkg::TrigW-1:0]  m12_o,
  output logic signed [erm_pkg::TrigW-1:0]  m20_o,
  output logic signed [erm_pkg::TrigW-1:0]  m21_o,
  output logic signed [erm_pkg::TrigW-1:0]  m22_o,
  output logic                              table_bad_o
);

  localparam int unsigned TW  = erm_pkg::TrigW;
  localparam int unsigned FW  = erm_pkg::FracW;
  localparam int unsigned P1W = erm_pkg::Prod1W;
  localparam int unsigned L1W = erm_pkg::Lvl1W;
  localparam int unsigned P2W = erm_pkg::Prod2W;

  // accept and busy
  logic busy_q, busy_d;
  logic accept, wr_en, cmp_en;

  assign busy_d = 1'b0;
  assign busy_o = busy_q;
  assign accept = start_i & ~busy_q;
  assign wr_en  = accept & (func_i == erm_pkg::FUNC_WRITE);
  assign cmp_en = accept & (func_i == erm_pkg::FUNC_COMPUTE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
    end
  end

  // trig table: two copies written alike, so three angles are looked up per cycle
  // copy a serves x and y, copy b serves z
  logic [erm_pkg::WordW-1:0] tab_a [erm_pkg::TableEntries];
  logic [erm_pkg::WordW-1:0] tab_b [erm_pkg::TableEntries];
  logic [erm_pkg::WordW-1:0] rd_x_q, rd_y_q, rd_z_q;
  logic [erm_pkg::IdxW-1:0]  idx_x, idx_y, idx_z;

  assign idx_x = erm_pkg::trig_index(angle_x_i);
  assign idx_y = erm_pkg::trig_index(angle_y_i);
  assign idx_z = erm_pkg::trig_index(angle_z_i);

  // a write lands at its accept edge, so a compute word in the next cycle already
  // reads the new entry; a read at the write's own edge still returns the old entry
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tab_a[table_index_i] <= table_word_i;
    end
    rd_x_q <= tab_a[idx_x];
    rd_y_q <= tab_a[idx_y];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tab_b[table_index_i] <= table_word_i;
    end
    rd_z_q <= tab_b[idx_z];
  end

  // entry 0 check kept in a flag alongside the table, updated on each write of entry 0
  logic bad_q, bad_d;

  always_comb begin
    bad_d = bad_q;
    if (wr_en && (table_index_i == '0)) begin
      bad_d = (table_word_i != erm_pkg::GoodEntry0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q <= 1'b1;
    end else begin
      bad_q <= bad_d;
    end
  end

  // pipeline valids
  logic [erm_pkg::Latency-1:0] vld_q, vld_d;

  assign vld_d = {vld_q[erm_pkg::Latency-2:0], cmp_en};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 0: angle signs and flag ride along with the table read
  logic neg_x0_q, neg_y0_q, neg_z0_q, bad0_q;

  always_ff @(posedge clk_i) begin
    neg_x0_q <= angle_x_i[erm_pkg::AngleW-1];
    neg_y0_q <= angle_y_i[erm_pkg::AngleW-1];
    neg_z0_q <= angle_z_i[erm_pkg::AngleW-1];
    bad0_q   <= bad_d;
  end

  // stage 1: unpack sine and cosine, apply the angle sign to the sine
  erm_pkg::trig_t sx1_q, cx1_q, sy1_q, cy1_q, sz1_q, cz1_q;
  logic bad1_q;

  always_ff @(posedge clk_i) begin
    sx1_q  <= erm_pkg::sine_fix(rd_x_q[TW-1:0], neg_x0_q);
    sy1_q  <= erm_pkg::sine_fix(rd_y_q[TW-1:0], neg_y0_q);
    sz1_q  <= erm_pkg::sine_fix(rd_z_q[TW-1:0], neg_z0_q);
    cx1_q  <= erm_pkg::trig_t'(rd_x_q[2*TW-1:TW]);
    cy1_q  <= erm_pkg::trig_t'(rd_y_q[2*TW-1:TW]);
    cz1_q  <= erm_pkg::trig_t'(rd_z_q[2*TW-1:TW]);
    bad1_q <= bad0_q;
  end

  // stage 2: first-level products, floor shift is a plain part-select
  logic signed [P1W-1:0] p_sxsy, p_cxsy, p_cycz, p_szcy, p_sxcy, p_cxcy;
  logic signed [P1W-1:0] p_szcx, p_sxsz, p_cxcz, p_sxcz;

  assign p_sxsy = sx1_q * sy1_q;
  assign p_cxsy = cx1_q * sy1_q;
  assign p_cycz = cy1_q * cz1_q;
  assign p_szcy = sz1_q * cy1_q;
  assign p_sxcy = sx1_q * cy1_q;
  assign p_cxcy = cx1_q * cy1_q;
  assign p_szcx = sz1_q * cx1_q;
  assign p_sxsz = sx1_q * sz1_q;
  assign p_cxcz = cx1_q * cz1_q;
  assign p_sxcz = sx1_q * cz1_q;

  // a and b keep their full shifted width for the second products; the rest only
  // reach the outputs, which keep the low bits alone
  logic signed [L1W-1:0] a2_q, b2_q;
  logic [TW-1:0] m00_2_q, m10_2_q, m21_2_q, m22_2_q;
  logic [TW-1:0] szcx2_q, sxsz2_q, cxcz2_q, sxcz2_q, m20_2_q;
  erm_pkg::trig_t sz2_q, cz2_q;
  logic bad2_q;

  always_ff @(posedge clk_i) begin
    a2_q    <= p_sxsy[P1W-1:FW];
    b2_q    <= p_cxsy[P1W-1:FW];
    m00_2_q <= p_cycz[FW+TW-1:FW];
    m10_2_q <= p_szcy[FW+TW-1:FW];
    m21_2_q <= p_sxcy[FW+TW-1:FW];
    m22_2_q <= p_cxcy[FW+TW-1:FW];
    szcx2_q <= p_szcx[FW+TW-1:FW];
    sxsz2_q <= p_sxsz[FW+TW-1:FW];
    cxcz2_q <= p_cxcz[FW+TW-1:FW];
    sxcz2_q <= p_sxcz[FW+TW-1:FW];
    m20_2_q <= TW'(0) - sy1_q;
    sz2_q   <= sz1_q;
    cz2_q   <= cz1_q;
    bad2_q  <= bad1_q;
  end

  // stage 3: second-level products from a and b
  logic signed [P2W-1:0] p_acz, p_asz, p_bcz, p_bsz;

  assign p_acz = a2_q * cz2_q;
  assign p_asz = a2_q * sz2_q;
  assign p_bcz = b2_q * cz2_q;
  assign p_bsz = b2_q * sz2_q;

  logic [TW-1:0] acz3_q, asz3_q, bcz3_q, bsz3_q;
  logic [TW-1:0] m00_3_q, m10_3_q, m21_3_q, m22_3_q;
  logic [TW-1:0] szcx3_q, sxsz3_q, cxcz3_q, sxcz3_q, m20_3_q;
  logic bad3_q;

  always_ff @(posedge clk_i) begin
    acz3_q  <= p_acz[FW+TW-1:FW];
    asz3_q  <= p_asz[FW+TW-1:FW];
    bcz3_q  <= p_bcz[FW+TW-1:FW];
    bsz3_q  <= p_bsz[FW+TW-1:FW];
    m00_3_q <= m00_2_q;
    m10_3_q <= m10_2_q;
    m21_3_q <= m21_2_q;
    m22_3_q <= m22_2_q;
    szcx3_q <= szcx2_q;
    sxsz3_q <= sxsz2_q;
    cxcz3_q <= cxcz2_q;
    sxcz3_q <= sxcz2_q;
    m20_3_q <= m20_2_q;
    bad3_q  <= bad2_q;
  end

  // stage 4: sums wrap to 16 bits, output register
  logic [TW-1:0] m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
  logic          tbad_q;

  always_ff @(posedge clk_i) begin
    m00_q  <= m00_3_q;
    m01_q  <= acz3_q - szcx3_q;
    m02_q  <= bcz3_q + sxsz3_q;
    m10_q  <= m10_3_q;
    m11_q  <= asz3_q + cxcz3_q;
    m12_q  <= bsz3_q - sxcz3_q;
    m20_q  <= m20_3_q;
    m21_q  <= m21_3_q;
    m22_q  <= m22_3_q;
    tbad_q <= bad3_q;
  end

  assign done_o      = vld_q[erm_pkg::Latency-1];
  assign m00_o       = erm_pkg::trig_t'(m00_q);
  assign m01_o       = erm_pkg::trig_t'(m01_q);
  assign m02_o       = erm_pkg::trig_t'(m02_q);
  assign m10_o       = erm_pkg::trig_t'(m10_q);
  assign m11_o       = erm_pkg::trig_t'(m11_q);
  assign m12_o       = erm_pkg::trig_t'(m12_q);
  assign m20_o       = erm_pkg::trig_t'(m20_q);
  assign m21_o       = erm_pkg::trig_t'(m21_q);
  assign m22_o       = erm_pkg::trig_t'(m22_q);
  assign table_bad_o = tbad_q;

endmodule

@@ sv/erm_checker.sv @@
// erm_checker: port-level checks on euler_to_rotation_matrix_q12, bound to the top level
// depends on erm_pkg
module erm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic func_i,
  input logic done_o
);

  logic acc_cmp, acc_wr;

  assign acc_cmp = start_i && !busy_o && (func_i == erm_pkg::FUNC_COMPUTE);
  assign acc_wr  = start_i && !busy_o && (func_i == erm_pkg::FUNC_WRITE);

  // every compute word yields its result on done_o
  a_cmp_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_cmp |-> ##5 done_o)
    else $error("compute word without result");

  // no result appears without a compute word at the matching edge
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(acc_cmp, 5))
    else $error("result without compute word");

  // a table write never gives a result
  a_wr_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_wr |-> ##5 !done_o)
    else $error("table write gave a result");

  // once out of reset the block keeps taking words
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |=> !busy_o)
    else $error("busy after reset");

endmodule

bind euler_to_rotation_matrix_q12 erm_checker u_erm_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .func_i  (func_i),
  .done_o  (done_o)
);
